FILE: src/lgt_pkg.sv
`default_nettype none

package lgt_pkg;

	typedef enum logic [1:0] {
		MODE_SETUP = 2'd0,
		MODE_READY = 2'd1,
		MODE_RUN   = 2'd2
	} run_mode_t;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic REG_MIN_PULSE = 1'b0;
	localparam logic REG_MIN_RUN   = 1'b1;

	localparam int unsigned PADDR_W = 3;

	localparam logic [9:0]  MIN_PULSE_RESET = 10'd15;
	localparam logic [15:0] MIN_RUN_RESET   = 16'd500;

	typedef struct packed {
		logic [9:0]  min_pulse_ms;
		logic [15:0] min_run_ms;
	} cfg_t;

	typedef struct packed {
		logic       func;
		logic       mode_switch;
		logic       start_button;
		logic       gate_level;
		logic [4:0] lap_index;
	} item_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        led;
		logic [31:0] elapsed_ms;
		logic        lap_recorded;
		logic        crossing_rejected;
		logic [31:0] lap_ms;
		logic [5:0]  lap_count;
		logic        laps_full;
		logic        read_valid;
	} result_t;

endpackage

`default_nettype wire

FILE: src/lgt_if.sv
`default_nettype none

// Input channel: one word is a tick or a lap read request.
interface lgt_item_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic       mode_switch;
	logic       start_button;
	logic       gate_level;
	logic [4:0] lap_index;

	modport source (output valid, output func, output mode_switch, output start_button,
		output gate_level, output lap_index, input ready);
	modport sink (input valid, input func, input mode_switch, input start_button,
		input gate_level, input lap_index, output ready);
endinterface

// Output channel: one word of timer status per input word.
interface lgt_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic        led;
	logic [31:0] elapsed_ms;
	logic        lap_recorded;
	logic        crossing_rejected;
	logic [31:0] lap_ms;
	logic [5:0]  lap_count;
	logic        laps_full;
	logic        read_valid;

	modport source (output valid, output mode, output led, output elapsed_ms,
		output lap_recorded, output crossing_rejected, output lap_ms, output lap_count,
		output laps_full, output read_valid, input ready);
	modport sink (input valid, input mode, input led, input elapsed_ms,
		input lap_recorded, input crossing_rejected, input lap_ms, input lap_count,
		input laps_full, input read_valid, output ready);
endinterface

`default_nettype wire

FILE: src/lgt_apb_regs.sv
`default_nettype none

module lgt_apb_regs
	import lgt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	logic reg_idx;
	logic wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.min_pulse_ms <= MIN_PULSE_RESET;
			cfg.min_run_ms   <= MIN_RUN_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MIN_PULSE: cfg.min_pulse_ms <= pwdata[9:0];
				REG_MIN_RUN:   cfg.min_run_ms   <= pwdata[15:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MIN_PULSE: prdata = {22'd0, cfg.min_pulse_ms};
			REG_MIN_RUN:   prdata = {16'd0, cfg.min_run_ms};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/lgt_lap_ram.sv
`default_nettype none

module lgt_lap_ram #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Write-first: a read that meets a write to the same entry sees the new data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/lgt_core.sv
`default_nettype none

module lgt_core
	import lgt_pkg::*;
#(
	parameter int unsigned LAP_DEPTH = 32,
	parameter int unsigned AW        = 5,
	parameter int unsigned SW        = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step_en,
	input  wire item_t         item_s1,
	input  wire cfg_t          cfg,
	input  wire logic [31:0]   rd_data,
	output logic               wr_en,
	output logic      [AW-1:0] wr_addr,
	output logic      [31:0]   wr_data,
	output result_t            res
);

	localparam int unsigned CW = (SW > 5) ? SW : 5;

	logic [31:0]   now_q, start_q, rise_q, fall_q;
	logic          rise_seen_q, fall_seen_q, last_gate_q, led_q;
	run_mode_t     mode_q;
	logic [SW-1:0] stored_q;

	logic [31:0]   now_n, start_n, rise_n, fall_n;
	logic          rise_seen_n, fall_seen_n, last_gate_n, led_n;
	run_mode_t     mode_n, mode_a;
	logic [SW-1:0] stored_n;

	logic [31:0]   pair_diff;
	logic          pair_ok;
	logic          recorded, rejected, full, rvalid, is_tick;
	logic [31:0]   lap;

	assign is_tick   = (item_s1.func == FUNC_TICK);
	assign pair_diff = fall_n - rise_n;
	assign pair_ok   = !pair_diff[31] && (pair_diff > {22'd0, cfg.min_pulse_ms});

	always_comb begin
		now_n       = now_q;
		start_n     = start_q;
		rise_n      = rise_q;
		fall_n      = fall_q;
		rise_seen_n = rise_seen_q;
		fall_seen_n = fall_seen_q;
		last_gate_n = last_gate_q;
		led_n       = led_q;
		mode_n      = mode_q;
		mode_a      = mode_q;
		stored_n    = stored_q;
		recorded    = 1'b0;
		rejected    = 1'b0;
		full        = 1'b0;
		rvalid      = 1'b0;
		lap         = 32'd0;
		wr_en       = 1'b0;
		wr_addr     = AW'(stored_q);
		wr_data     = 32'd0;

		if (is_tick) begin
			now_n = now_q + 32'd1;
			if (mode_q == MODE_RUN && item_s1.gate_level != last_gate_q) begin
				if (item_s1.gate_level) begin
					rise_n      = now_n;
					rise_seen_n = 1'b1;
				end else begin
					fall_n      = now_n;
					fall_seen_n = 1'b1;
				end
			end
			last_gate_n = item_s1.gate_level;

			if (mode_q != MODE_RUN) begin
				mode_a = item_s1.mode_switch ? MODE_SETUP : MODE_READY;
			end
			mode_n = mode_a;

			unique case (mode_a)
				MODE_SETUP: begin
					led_n = ~item_s1.gate_level;
				end
				MODE_READY: begin
					if (item_s1.start_button) begin
						start_n     = now_n;
						stored_n    = '0;
						rise_seen_n = 1'b0;
						fall_seen_n = 1'b0;
						mode_n      = MODE_RUN;
					end
				end
				MODE_RUN: begin
					if (rise_seen_n && fall_seen_n) begin
						if (pair_ok) begin
							lap = rise_n - start_q;
							if (stored_q < SW'(LAP_DEPTH)) begin
								wr_en    = 1'b1;
								wr_data  = lap;
								stored_n = stored_q + SW'(1);
								recorded = 1'b1;
							end else begin
								full = 1'b1;
							end
						end else begin
							rejected = 1'b1;
						end
						rise_seen_n = 1'b0;
						fall_seen_n = 1'b0;
					end
					if (item_s1.start_button &&
						((now_n - start_q) > {16'd0, cfg.min_run_ms})) begin
						mode_n = MODE_READY;
					end
				end
				default: ;
			endcase
		end else begin
			// Entries below the lap count were all written in the current run.
			if (CW'(item_s1.lap_index) < CW'(stored_q)) begin
				rvalid = 1'b1;
				lap    = rd_data;
			end
		end

		wr_en = wr_en & step_en;

		res.mode              = mode_n;
		res.led               = led_n;
		res.elapsed_ms        = (mode_n == MODE_RUN) ? (now_n - start_n) : 32'd0;
		res.lap_recorded      = recorded;
		res.crossing_rejected = rejected;
		res.lap_ms            = lap;
		res.lap_count         = 6'(stored_n);
		res.laps_full         = full;
		res.read_valid        = rvalid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= 32'd0;
			start_q     <= 32'd0;
			rise_q      <= 32'd0;
			fall_q      <= 32'd0;
			rise_seen_q <= 1'b0;
			fall_seen_q <= 1'b0;
			last_gate_q <= 1'b0;
			led_q       <= 1'b0;
			mode_q      <= MODE_SETUP;
			stored_q    <= '0;
		end else if (step_en) begin
			now_q       <= now_n;
			start_q     <= start_n;
			rise_q      <= rise_n;
			fall_q      <= fall_n;
			rise_seen_q <= rise_seen_n;
			fall_seen_q <= fall_seen_n;
			last_gate_q <= last_gate_n;
			led_q       <= led_n;
			mode_q      <= mode_n;
			stored_q    <= stored_n;
		end
	end

endmodule

`default_nettype wire

FILE: src/light_gate_lap_timer.sv
// An accepted word is held in the input register, and its result word is registered in
// the output register, from which it can be taken.
// Throughput: one word per cycle; the input register, the combinational step logic and
// the output register form a two-stage pipeline that stalls only on a held result.
// Reset (arst_n low, asynchronous): setup mode, all counters and stamps zero, no laps,
// registers back to min_pulse_ms = 15 and min_run_ms = 500; no clearing pass is run.
`default_nettype none

module light_gate_lap_timer
	import lgt_pkg::*;
#(
	parameter int unsigned LAP_DEPTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	lgt_item_if.sink                item,
	lgt_result_if.source            result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	// Lap store address width and the width of the lap counter, which must hold
	// the depth itself when the store is full.
	localparam int unsigned AW = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
	localparam int unsigned SW = $clog2(LAP_DEPTH + 1);

	cfg_t          cfg;
	item_t         item_in;
	item_t         item_s1;
	logic          valid_s1;
	result_t       res_next;
	result_t       res_q;
	logic          out_valid_q;
	logic          advance;
	logic          accept;
	logic          step_en;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic [31:0]   rd_data;

	// Configuration registers behind the APB port.
	lgt_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign item_in.func         = item.func;
	assign item_in.mode_switch  = item.mode_switch;
	assign item_in.start_button = item.start_button;
	assign item_in.gate_level   = item.gate_level;
	assign item_in.lap_index    = item.lap_index;

	// The output register frees up when it is empty or being drained this cycle.
	// The input stage moves on whenever the output register can take its result,
	// so the input register can still take one word while a finished word waits.
	assign advance    = !out_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign accept     = item.valid && item.ready;
	assign step_en    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	// The lap store read is launched when the word is accepted, so the data is
	// ready while the word sits in the input register. A lap written by the
	// word ahead at the same edge is forwarded by the store itself. Nothing else
	// writes the store while a read word waits, so the read data stays good.
	lgt_lap_ram #(
		.DEPTH (LAP_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (accept),
		.raddr (AW'(item.lap_index)),
		.rdata (rd_data)
	);

	// Mode machine, edge stamps, pair judgement and lap bookkeeping.
	lgt_core #(
		.LAP_DEPTH (LAP_DEPTH),
		.AW        (AW),
		.SW        (SW)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.res     (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res_next;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.mode              = res_q.mode;
	assign result.led               = res_q.led;
	assign result.elapsed_ms        = res_q.elapsed_ms;
	assign result.lap_recorded      = res_q.lap_recorded;
	assign result.crossing_rejected = res_q.crossing_rejected;
	assign result.lap_ms            = res_q.lap_ms;
	assign result.lap_count         = res_q.lap_count;
	assign result.laps_full         = res_q.laps_full;
	assign result.read_valid        = res_q.read_valid;

endmodule

`default_nettype wire
